@@ hw/rtl/scaled_palette_tile_blitter_macros.svh @@
// Assertion macros for the tile blitter.
`ifndef SCALED_PALETTE_TILE_BLITTER_MACROS_SVH
`define SCALED_PALETTE_TILE_BLITTER_MACROS_SVH
// assert that a implies b, checked at each rising edge outside reset
`define SPTB_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define SPTB_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/sptb_pkg.sv @@
// Shared types and codes of the tile blitter.
`default_nettype none
package sptb_pkg;
  localparam logic [2:0] MODE_DRAW = 3'd0;
  localparam logic [2:0] MODE_TEX = 3'd1;
  localparam logic [2:0] MODE_REMAP = 3'd2;
  localparam logic [2:0] MODE_RD = 3'd3;
  localparam logic [2:0] MODE_WR = 3'd4;
  localparam logic [1:0] STYLE_PLAIN = 2'd0;
  localparam logic [1:0] STYLE_MASK = 2'd1;
  localparam logic [1:0] STYLE_SOLID = 2'd2;
  localparam logic CFG_WLOG = 1'b0;
  localparam logic CFG_HLOG = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture input word
    logic simple;   // execute non-draw word
    logic div_start;
    logic setup;    // compute start accumulators
    logic row_start;
    logic px_issue; // issue one texel read
    logic rd_out;   // present read result
  } sptb_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_draw;
    logic reject;
    logic div_done;
    logic col_last;
    logic row_last;
    logic pipe_empty;
  } sptb_sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/sptb_ctrl.sv @@
// Controller state machine of the tile blitter.
`default_nettype none
`include "scaled_palette_tile_blitter_macros.svh"
module sptb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic               is_rd,
  input  wire logic               out_free,
  input  wire sptb_pkg::sptb_sts_t sts,
  output logic                    in_rdy,
  output sptb_pkg::sptb_cmd_t     cmd
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_DEC = 8'b00000010, S_DIV = 8'b00000100,
    S_SET = 8'b00001000, S_ROW = 8'b00010000, S_PIX = 8'b00100000,
    S_DRAIN = 8'b01000000, S_RD = 8'b10000000
  } st_t;
  st_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    in_rdy = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.is_draw) begin
          cmd.simple = 1'b1;
          st_nxt = is_rd ? S_RD : S_IDLE;
        end else if (sts.reject) st_nxt = S_IDLE;
        else begin
          cmd.div_start = 1'b1;
          st_nxt = S_DIV;
        end
      end
      S_DIV: if (sts.div_done) st_nxt = S_SET;
      S_SET: begin
        cmd.setup = 1'b1;
        st_nxt = S_ROW;
      end
      S_ROW: begin
        if (sts.row_last) st_nxt = S_DRAIN;
        else begin
          cmd.row_start = 1'b1;
          st_nxt = S_PIX;
        end
      end
      S_PIX: begin
        if (sts.col_last) st_nxt = S_ROW;
        else cmd.px_issue = 1'b1;
      end
      S_DRAIN: if (sts.pipe_empty) st_nxt = S_IDLE;
      S_RD: begin
        if (out_free) begin
          cmd.rd_out = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  `SPTB_ASSERT_IMPL(a_onehot, 1'b1, $onehot(st_r))
  `SPTB_ASSERT_IMPL(a_rdy_idle, in_rdy, st_r == S_IDLE)
  `SPTB_ASSERT_NEXT(a_load_dec, cmd.load, st_r == S_DEC)
endmodule
`default_nettype wire

@@ hw/rtl/sptb_div.sv @@
// Restoring divider for the per-axis step.
`default_nettype none
module sptb_div #(
  parameter int NW = 36,
  parameter int DW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW+1:0] trial;
  logic [DW:0]   sh;
  assign sh = {rem_r[DW-1:0], q_r[NW-1]};
  assign trial = {1'b0, sh} - {2'b0, den};
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (start) cnt_r <= CW'(NW);
    else if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
  end
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      if (!trial[DW+1]) begin
        rem_r <= trial[DW:0];
        q_r <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r <= {q_r[NW-2:0], 1'b0};
      end
    end
  end
  assign busy = cnt_r != '0;
  assign quo = q_r;
endmodule
`default_nettype wire

@@ hw/rtl/sptb_dp.sv @@
// Datapath of the tile blitter: stores, clipping, steps and pixel pipeline.
`default_nettype none
`include "scaled_palette_tile_blitter_macros.svh"
module sptb_dp #(
  parameter int DEST_WIDTH = 256,
  parameter int DEST_HEIGHT = 256,
  parameter int SRC_MAX_LOG2 = 8,
  parameter int STEP_FRAC_BITS = 19
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sptb_pkg::sptb_cmd_t cmd,
  output sptb_pkg::sptb_sts_t     sts,
  input  wire logic [2:0]         mode,
  input  wire logic [1:0]         style,
  input  wire logic [10:0]        dst_x,
  input  wire logic [10:0]        dst_y,
  input  wire logic [10:0]        dst_w,
  input  wire logic [10:0]        dst_h,
  input  wire logic [15:0]        src_u,
  input  wire logic [15:0]        src_v,
  input  wire logic [15:0]        src_w,
  input  wire logic [15:0]        src_h,
  input  wire logic [15:0]        address,
  input  wire logic [7:0]         value,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [3:0]         cfg_val,
  output logic [7:0]              rd_value,
  output logic [15:0]             rd_address
);
  localparam int F = STEP_FRAC_BITS;
  localparam int DSZ = DEST_WIDTH * DEST_HEIGHT;
  localparam int DAW = $clog2(DSZ);
  localparam int NW = 16 + F - 7;
  localparam int AW = 48;
  localparam int LW = $clog2(SRC_MAX_LOG2 + 1);

  logic [2:0] mode_r; logic [1:0] style_r;
  logic signed [12:0] x_r, y_r; logic [10:0] w_r, h_r;
  logic [15:0] su_r, sv_r, sw_r, sh_r, addr_r; logic [7:0] val_r;
  logic [3:0] wlog_r, hlog_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlog_r <= 4'd8; hlog_r <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_idx == sptb_pkg::CFG_WLOG) wlog_r <= cfg_val;
      else hlog_r <= cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode; style_r <= style;
      x_r <= 13'(signed'(dst_x)); y_r <= 13'(signed'(dst_y));
      w_r <= dst_w; h_r <= dst_h;
      su_r <= src_u; sv_r <= src_v; sw_r <= src_w; sh_r <= src_h;
      addr_r <= address; val_r <= value;
    end
  end

  logic [LW-1:0] wl, hl;
  assign wl = (wlog_r > 4'(SRC_MAX_LOG2)) ? LW'(SRC_MAX_LOG2) : LW'(wlog_r);
  assign hl = (hlog_r > 4'(SRC_MAX_LOG2)) ? LW'(SRC_MAX_LOG2) : LW'(hlog_r);

  logic signed [12:0] xe, ye;
  assign xe = x_r + 13'(w_r);
  assign ye = y_r + 13'(h_r);
  logic rej;
  assign rej = style_r == 2'd3 || w_r == '0 || h_r == '0 || xe < 0 || ye < 0
             || x_r > 13'(DEST_WIDTH) || y_r > 13'(DEST_HEIGHT);
  logic [12:0] dx1, dx2, dy1, dy2;
  always_comb begin
    dx1 = x_r < 0 ? '0 : x_r;
    if (dx1 > 13'(DEST_WIDTH - 1)) dx1 = 13'(DEST_WIDTH - 1);
    dx2 = xe > 13'(DEST_WIDTH - 1) ? 13'(DEST_WIDTH - 1) : xe;
    dy1 = y_r < 0 ? '0 : y_r;
    if (dy1 > 13'(DEST_HEIGHT - 1)) dy1 = 13'(DEST_HEIGHT - 1);
    dy2 = ye > 13'(DEST_HEIGHT - 1) ? 13'(DEST_HEIGHT - 1) : ye;
  end

  // step = (src*2^(F-7) + dst) / (2*dst)
  logic dv_busy_x, dv_busy_y; logic [NW-1:0] qx, qy;
  sptb_div #(.NW(NW), .DW(12)) u_divx (.clk, .rst_n, .start(cmd.div_start),
    .num((NW'(sw_r) << (F - 7)) + NW'(w_r)), .den({w_r, 1'b0}),
    .busy(dv_busy_x), .quo(qx));
  sptb_div #(.NW(NW), .DW(12)) u_divy (.clk, .rst_n, .start(cmd.div_start),
    .num((NW'(sh_r) << (F - 7)) + NW'(h_r)), .den({h_r, 1'b0}),
    .busy(dv_busy_y), .quo(qy));

  logic [AW-1:0] fixu_r, accu_r, accv_r;
  logic [12:0] cx_r, cy_r, dx2_r, dy2_r, dx1_r;
  logic [12:0] offx, offy;
  logic [NW+12:0] mulx, muly;
  assign offx = dx1 - x_r;
  assign offy = dy1 - y_r;
  assign mulx = offx * qx;
  assign muly = offy * qy;
  // cy_r holds the next row to draw
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      fixu_r <= (AW'(su_r) << (F - 8)) + AW'(mulx) - AW'(qx);
      accv_r <= (AW'(sv_r) << (F - 8)) + AW'(muly) - AW'(qy);
      cy_r <= dy1; dy2_r <= dy2; dx1_r <= dx1; dx2_r <= dx2;
    end else if (cmd.row_start) begin
      accv_r <= accv_r + AW'(qy);
      accu_r <= fixu_r;
      cx_r <= dx1_r;
      cy_r <= cy_r + 1'b1;
    end else if (cmd.px_issue) begin
      accu_r <= accu_r + AW'(qx);
      cx_r <= cx_r + 1'b1;
    end
  end

  logic [15:0] rowsel, colsel;
  logic [AW-1:0] accu_n, accv_n;
  assign accv_n = accv_r + AW'(qy);
  assign accu_n = accu_r + AW'(qx);
  logic [15:0] row_r;
  logic [12:0] ydraw_r;
  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      row_r <= 16'((accv_n >> F) & ((AW'(1) << hl) - 1'b1)) << wl;
      ydraw_r <= cy_r;
    end
  end
  assign colsel = 16'((accu_n >> F) & ((AW'(1) << wl) - 1'b1));
  assign rowsel = row_r;

  // stage 1: texel read
  logic [7:0] tex_mem [0:65535];
  logic [7:0] remap_mem [0:255];
  logic [7:0] dest_mem [0:DSZ-1];
  logic p1_v_r, p2_v_r; logic [DAW-1:0] p1_a_r, p2_a_r;
  logic [7:0] tex_q_r, rmp_q_r, tex2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin p1_v_r <= 1'b0; p2_v_r <= 1'b0; end
    else begin p1_v_r <= cmd.px_issue; p2_v_r <= p1_v_r; end
  end
  always_ff @(posedge clk) begin
    if (cmd.simple && mode_r == sptb_pkg::MODE_TEX) tex_mem[addr_r] <= val_r;
    tex_q_r <= tex_mem[rowsel + colsel];
    p1_a_r <= DAW'(32'(ydraw_r) * DEST_WIDTH + 32'(cx_r));
  end
  always_ff @(posedge clk) begin
    if (cmd.simple && mode_r == sptb_pkg::MODE_REMAP && addr_r[15:8] == '0)
      remap_mem[addr_r[7:0]] <= val_r;
    rmp_q_r <= remap_mem[tex_q_r];
    tex2_r <= tex_q_r; p2_a_r <= p1_a_r;
  end
  logic dwe; logic [DAW-1:0] dwa; logic [7:0] dwd;
  logic in_rng;
  assign in_rng = 32'(addr_r) < DSZ;
  always_comb begin
    dwe = 1'b0; dwa = p2_a_r; dwd = rmp_q_r;
    if (p2_v_r) begin
      if (style_r == sptb_pkg::STYLE_PLAIN) dwe = 1'b1;
      else if (tex2_r != '0) begin
        dwe = 1'b1;
        if (style_r == sptb_pkg::STYLE_SOLID) dwd = val_r;
      end
    end else if (cmd.simple && mode_r == sptb_pkg::MODE_WR && in_rng) begin
      dwe = 1'b1; dwa = DAW'(addr_r); dwd = val_r;
    end
  end
  logic [7:0] dq_r; logic rng_r;
  always_ff @(posedge clk) begin
    if (dwe) dest_mem[dwa] <= dwd;
    dq_r <= dest_mem[DAW'(addr_r)];
    rng_r <= in_rng;
  end
  assign rd_value = rng_r ? dq_r : 8'd0;
  assign rd_address = addr_r;

  assign sts.is_draw = mode_r == sptb_pkg::MODE_DRAW;
  assign sts.reject = rej;
  assign sts.div_done = !dv_busy_x && !dv_busy_y;
  assign sts.col_last = cx_r >= dx2_r;
  assign sts.row_last = cy_r >= dy2_r;
  assign sts.pipe_empty = !p1_v_r && !p2_v_r;

  `SPTB_ASSERT_NEXT(a_pipe, cmd.px_issue, p1_v_r)
  `SPTB_ASSERT_IMPL(a_nodiv, cmd.setup, sts.div_done)
  `SPTB_ASSERT_IMPL(a_excl, p2_v_r, !cmd.simple)
endmodule
`default_nettype wire

@@ hw/rtl/scaled_palette_tile_blitter.sv @@
// Top level of the scaled palette tile blitter.
// One word is handled at a time. A load, write or unused-mode word passes
// through accept and decode; a read then presents its result once the output
// register is free or out_tready is high. A draw passes through accept, decode,
// the step dividers (one quotient bit per cycle), setup, a row step before each
// row and one pixel issue per clipped pixel, then drains the pixel pipeline.
// A rejected draw ends after decode.
`default_nettype none
module scaled_palette_tile_blitter #(
  parameter int DEST_WIDTH = 256,
  parameter int DEST_HEIGHT = 256,
  parameter int SRC_MAX_LOG2 = 8,
  parameter int STEP_FRAC_BITS = 19
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // style, dst_x, dst_y, dst_w, dst_h, src_u, src_v, src_w, src_h,
  // address, value (lowest bit up), zero fill to 136 bits
  input  wire logic [135:0] in_tdata,
  // mode
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pixel_value, pixel_address (lowest bit up)
  output logic [23:0]       out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [3:0]   cfg_data
);
  sptb_pkg::sptb_cmd_t cmd;
  sptb_pkg::sptb_sts_t sts;
  logic [7:0] rdv; logic [15:0] rda;
  logic in_fire;
  logic rd_mode_r;
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_mode_r <= 1'b0;
    else if (in_fire) rd_mode_r <= in_tuser == sptb_pkg::MODE_RD;
  end

  sptb_ctrl u_ctrl (.clk, .rst_n, .in_fire, .is_rd(rd_mode_r),
    .out_free(!out_tvalid || out_tready), .sts, .in_rdy(in_tready), .cmd);

  sptb_dp #(.DEST_WIDTH(DEST_WIDTH), .DEST_HEIGHT(DEST_HEIGHT),
    .SRC_MAX_LOG2(SRC_MAX_LOG2), .STEP_FRAC_BITS(STEP_FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .mode(in_tuser), .style(in_tdata[1:0]),
    .dst_x(in_tdata[12:2]), .dst_y(in_tdata[23:13]),
    .dst_w(in_tdata[34:24]), .dst_h(in_tdata[45:35]),
    .src_u(in_tdata[61:46]), .src_v(in_tdata[77:62]),
    .src_w(in_tdata[93:78]), .src_h(in_tdata[109:94]),
    .address(in_tdata[125:110]), .value(in_tdata[133:126]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .rd_value(rdv), .rd_address(rda));

  logic ov_r; logic [23:0] od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.rd_out) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) if (cmd.rd_out) od_r <= {rda, rdv};
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
endmodule
`default_nettype wire

@@ tb/tb_scaled_palette_tile_blitter.sv @@
// Self-checking testbench for the scaled palette tile blitter: drives draw, load and read words.
`default_nettype none
module tb_scaled_palette_tile_blitter;
  localparam int DW = 256;
  localparam int DH = 256;
  localparam int LOG_MAX = 8;
  localparam int FRAC = 19;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] STYLE_NONE = 2'd3;
  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;

  typedef struct {
    logic [2:0] mode;
    logic [1:0] style;
    logic signed [10:0] dst_x;
    logic signed [10:0] dst_y;
    logic [10:0] dst_w;
    logic [10:0] dst_h;
    logic [15:0] src_u;
    logic [15:0] src_v;
    logic [15:0] src_w;
    logic [15:0] src_h;
    logic [15:0] address;
    logic [7:0] value;
  } blit_word_t;

  typedef struct {
    logic [7:0] pix;
    logic [15:0] addr;
  } pixel_read_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [135:0] in_data = '0;
  logic [2:0] in_user = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = sptb_pkg::CFG_WLOG;
  logic [3:0] cfg_data = 4'd0;
  wire in_tready;
  wire out_tvalid;
  wire [23:0] out_tdata;
  wire cfg_ready;

  scaled_palette_tile_blitter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_valid), .in_tready(in_tready), .in_tdata(in_data), .in_tuser(in_user),
    .out_tvalid(out_tvalid), .out_tready(out_ready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirrored block state
  logic [7:0] dest_mem [DW*DH];
  bit dest_ok [DW*DH];
  logic [7:0] tex_mem [65536];
  bit tex_ok [65536];
  logic [7:0] remap_mem [256];
  logic [3:0] wlog_reg = 4'd8;
  logic [3:0] hlog_reg = 4'd8;
  logic [15:0] last_dest = 16'd0;

  pixel_read_t pending_reads [$];
  int unsigned missing_texels [$];
  bit missing_seen [int unsigned];
  int errors = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_left = 0;

  task automatic report(input string what, input longint exp_v, input longint got_v);
    $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  function automatic logic [135:0] pack_word(input blit_word_t w);
    return {2'd0, w.value, w.address, w.src_h, w.src_w, w.src_v, w.src_u,
            w.dst_h, w.dst_w, w.dst_y, w.dst_x, w.style};
  endfunction

  function automatic blit_word_t blank_word(input logic [2:0] mode);
    blit_word_t w;
    w = '{default: '0};
    w.mode = mode;
    return w;
  endfunction

  // walk a draw; commit=0 only collects unwritten texels it would read
  task automatic walk_draw(input blit_word_t w, input bit commit);
    longint x, y, wd, ht, dx1, dx2, dy1, dy2, dx, dy;
    logic [63:0] stx, sty, fixu, accv, accu, row, umask, vmask;
    int wl, hl;
    int unsigned ti, di;
    logic [7:0] t;
    x = longint'(w.dst_x);
    y = longint'(w.dst_y);
    wd = longint'(w.dst_w);
    ht = longint'(w.dst_h);
    if (w.style == STYLE_NONE || wd == 0 || ht == 0) return;
    if (x + wd < 0 || y + ht < 0 || x > DW || y > DH) return;
    wl = (wlog_reg > LOG_MAX) ? LOG_MAX : wlog_reg;
    hl = (hlog_reg > LOG_MAX) ? LOG_MAX : hlog_reg;
    umask = (64'd1 << wl) - 1;
    vmask = (64'd1 << hl) - 1;
    dx1 = (x < 0) ? 0 : x;
    if (dx1 > DW - 1) dx1 = DW - 1;
    dx2 = (x + wd > DW - 1) ? DW - 1 : x + wd;
    dy1 = (y < 0) ? 0 : y;
    if (dy1 > DH - 1) dy1 = DH - 1;
    dy2 = (y + ht > DH - 1) ? DH - 1 : y + ht;
    stx = ((64'(w.src_w) << (FRAC - 8)) * 2 + 64'(wd)) / (64'(wd) * 2);
    sty = ((64'(w.src_h) << (FRAC - 8)) * 2 + 64'(ht)) / (64'(ht) * 2);
    fixu = (64'(w.src_u) << (FRAC - 8)) + 64'((dx1 - x) * longint'(stx)) - stx;
    accv = (64'(w.src_v) << (FRAC - 8)) + 64'((dy1 - y) * longint'(sty)) - sty;
    for (dy = dy1; dy < dy2; dy++) begin
      accu = fixu;
      accv += sty;
      row = ((accv >> FRAC) & vmask) << wl;
      for (dx = dx1; dx < dx2; dx++) begin
        accu += stx;
        ti = 32'((row + ((accu >> FRAC) & umask)) & 64'hFFFF);
        if (!commit) begin
          if (!tex_ok[ti] && !missing_seen.exists(ti)) begin
            missing_seen[ti] = 1'b1;
            missing_texels.push_back(ti);
          end
        end else begin
          t = tex_mem[ti];
          di = 32'(dy * DW + dx);
          if (w.style == sptb_pkg::STYLE_PLAIN || t != 8'd0) begin
            dest_mem[di] = (w.style == sptb_pkg::STYLE_SOLID) ? w.value : remap_mem[t];
            dest_ok[di] = 1'b1;
            last_dest = 16'(di);
          end
        end
      end
    end
  endtask

  task automatic apply_word(input blit_word_t w);
    case (w.mode)
      sptb_pkg::MODE_DRAW: walk_draw(w, 1'b1);
      sptb_pkg::MODE_TEX: begin
        tex_mem[w.address] = w.value;
        tex_ok[w.address] = 1'b1;
      end
      sptb_pkg::MODE_REMAP: if (w.address < 256) remap_mem[w.address[7:0]] = w.value;
      sptb_pkg::MODE_RD: pending_reads.push_back('{dest_mem[w.address], w.address});
      sptb_pkg::MODE_WR: begin
        dest_mem[w.address] = w.value;
        dest_ok[w.address] = 1'b1;
        last_dest = w.address;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_word(input blit_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data <= pack_word(w);
    in_user <= w.mode;
    do @(posedge clk); while (!in_tready);
    apply_word(w);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_draw(input blit_word_t w);
    blit_word_t tw;
    missing_texels.delete();
    missing_seen.delete();
    walk_draw(w, 1'b0);
    foreach (missing_texels[i]) begin
      tw = blank_word(sptb_pkg::MODE_TEX);
      tw.address = 16'(missing_texels[i]);
      tw.value = 8'($urandom);
      send_word(tw);
    end
    send_word(w);
  endtask

  task automatic send_read();
    blit_word_t w;
    logic [15:0] a;
    w = blank_word(sptb_pkg::MODE_RD);
    w.address = last_dest;
    for (int n = 0; n < 32; n++) begin
      a = 16'($urandom);
      if (dest_ok[a]) begin
        w.address = a;
        break;
      end
    end
    send_word(w);
  endtask

  // flush with a read so any running draw is done, then wait for results
  task automatic settle();
    send_read();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sptb_pkg::CFG_WLOG) wlog_reg = val; else hlog_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic blit_word_t rand_draw(input bit wide);
    blit_word_t w;
    w = blank_word(sptb_pkg::MODE_DRAW);
    w.style = 2'($urandom_range(2));
    if ($urandom_range(19) == 0) w.style = STYLE_NONE;
    w.src_u = 16'($urandom);
    w.src_v = 16'($urandom);
    w.src_w = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4096));
    w.src_h = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4096));
    w.value = 8'($urandom);
    if (wide) begin
      w.dst_x = 11'($urandom_range(40) - 20);
      w.dst_y = 11'($urandom_range(40) - 20);
      w.dst_w = 11'($urandom_range(1024, 200));
      w.dst_h = 11'($urandom_range(1024, 200));
    end else if ($urandom_range(9) == 0) begin
      w.dst_x = 11'($urandom);
      w.dst_y = 11'($urandom);
      w.dst_w = 11'($urandom_range(1024));
      w.dst_h = 11'($urandom_range(1024));
    end else begin
      w.dst_x = 11'($urandom_range(280) - 20);
      w.dst_y = 11'($urandom_range(280) - 20);
      w.dst_w = 11'($urandom_range(12, 1));
      w.dst_h = 11'($urandom_range(12, 1));
    end
    return w;
  endfunction

  task automatic rand_mix(input int count);
    blit_word_t w;
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 45) send_draw(rand_draw(1'b0));
      else if (r < 75) send_read();
      else if (r < 85) begin
        w = blank_word(sptb_pkg::MODE_WR);
        w.address = 16'($urandom);
        w.value = 8'($urandom);
        send_word(w);
      end else if (r < 93) begin
        w = blank_word(sptb_pkg::MODE_REMAP);
        w.address = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(255));
        w.value = 8'($urandom);
        send_word(w);
      end else if (r < 97) begin
        w = blank_word(sptb_pkg::MODE_TEX);
        w.address = 16'($urandom);
        w.value = 8'($urandom);
        send_word(w);
      end else begin
        w = blank_word(MODE_SPARE_A + 3'($urandom_range(2)));
        w.address = 16'($urandom);
        send_word(w);
      end
    end
  endtask

  task automatic test_remap_load();
    blit_word_t w;
    for (int i = 0; i < 256; i++) begin
      w = blank_word(sptb_pkg::MODE_REMAP);
      w.address = 16'(i);
      w.value = 8'($urandom);
      send_word(w);
    end
    w.address = 16'hFFFF;
    w.value = 8'hFF;
    send_word(w);
    w.address = 16'h0100;
    send_word(w);
  endtask

  task automatic test_directed();
    blit_word_t w;
    w = blank_word(sptb_pkg::MODE_WR);
    w.value = 8'hFF;
    send_word(w);
    w.address = 16'hFFFF;
    w.value = 8'h00;
    send_word(w);
    w = blank_word(sptb_pkg::MODE_RD);
    send_word(w);
    w.address = 16'hFFFF;
    send_word(w);
    for (int s = 0; s < 4; s++) begin
      w = blank_word(sptb_pkg::MODE_DRAW);
      w.style = 2'(s);
      w.dst_x = 11'sd2;
      w.dst_y = 11'sd3;
      w.dst_w = 11'd5;
      w.dst_h = 11'd4;
      w.src_w = 16'h0500;
      w.src_h = 16'h0300;
      w.value = 8'hA5;
      send_draw(w);
    end
    w.style = sptb_pkg::STYLE_PLAIN;
    w.dst_w = 11'd0;
    send_draw(w);
    w.dst_w = 11'd4;
    w.dst_h = 11'd0;
    send_draw(w);
    w.dst_h = 11'd4;
    w.dst_x = 11'h400;
    w.dst_w = 11'd1;
    send_draw(w);
    w.dst_x = 11'sd257;
    send_draw(w);
    w.dst_x = 11'sd256;
    w.dst_y = 11'sd250;
    w.dst_w = 11'd8;
    send_draw(w);
    w.dst_x = 11'sd10;
    w.dst_y = 11'sd257;
    send_draw(w);
    w.dst_x = 11'sd1023;
    w.dst_y = 11'h400;
    send_draw(w);
    w.style = sptb_pkg::STYLE_MASK;
    w.dst_x = -11'sd1000;
    w.dst_y = -11'sd1000;
    w.dst_w = 11'd1024;
    w.dst_h = 11'd1023;
    w.src_u = 16'hFFFF;
    w.src_v = 16'hFFFF;
    w.src_w = 16'hFFFF;
    w.src_h = 16'hFFFF;
    send_draw(w);
    w.style = sptb_pkg::STYLE_SOLID;
    w.dst_x = 11'sd250;
    w.dst_y = -11'sd3;
    w.dst_w = 11'd20;
    w.dst_h = 11'd9;
    w.value = 8'hFF;
    send_draw(w);
    w = blank_word(MODE_SPARE_A);
    send_word(w);
    w.mode = MODE_SPARE_B;
    send_word(w);
    w.mode = MODE_SPARE_C;
    w.address = 16'hFFFF;
    w.value = 8'hFF;
    send_word(w);
    repeat (4) send_read();
    settle();
  endtask

  task automatic test_config_sweep();
    logic [3:0] wv [6] = '{4'd0, 4'd15, 4'd1, 4'd2, 4'd3, 4'd9};
    logic [3:0] hv [6] = '{4'd9, 4'd0, 4'd3, 4'd2, 4'd1, 4'd0};
    for (int i = 0; i < 6; i++) begin
      write_reg(sptb_pkg::CFG_WLOG, wv[i]);
      write_reg(sptb_pkg::CFG_HLOG, hv[i]);
      rand_mix(50);
      settle();
    end
    write_reg(sptb_pkg::CFG_WLOG, 4'd2);
    write_reg(sptb_pkg::CFG_HLOG, 4'd2);
    repeat (3) send_draw(rand_draw(1'b1));
    rand_mix(20);
    settle();
  endtask

  task automatic test_random_bulk();
    for (int i = 0; i < 8; i++) begin
      if (i == 0) begin
        write_reg(sptb_pkg::CFG_WLOG, 4'd12);
        write_reg(sptb_pkg::CFG_HLOG, 4'd0);
      end else begin
        write_reg(sptb_pkg::CFG_WLOG, 4'($urandom_range(3)));
        write_reg(sptb_pkg::CFG_HLOG, 4'($urandom_range(3)));
      end
      no_idle = (i % 3 == 2);
      rand_mix(80);
      settle();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_req++;
    repeat (60) send_read();
    no_idle = 1'b0;
    settle();
  endtask

  task automatic test_pause();
    rand_mix(30);
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    rand_mix(30);
    settle();
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < 75) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    pixel_read_t exp_r;
    if (rst_n && out_tvalid && out_ready) begin
      if (pending_reads.size() == 0) begin
        report("unexpected word", 0, out_tdata);
      end else begin
        exp_r = pending_reads.pop_front();
        if (out_tdata[7:0] !== exp_r.pix) report("pixel_value", exp_r.pix, out_tdata[7:0]);
        if (out_tdata[23:8] !== exp_r.addr)
          report("pixel_address", exp_r.addr, out_tdata[23:8]);
      end
    end
  end

  initial begin
    #400_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_remap_load();
    test_directed();
    test_config_sweep();
    test_random_bulk();
    test_backpressure();
    test_pause();
    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ scaled_palette_tile_blitter.f @@
+incdir+hw/rtl
hw/rtl/sptb_pkg.sv
hw/rtl/sptb_ctrl.sv
hw/rtl/sptb_div.sv
hw/rtl/sptb_dp.sv
hw/rtl/scaled_palette_tile_blitter.sv
tb/tb_scaled_palette_tile_blitter.sv
